### rtl/assert_macros.svh
// Assertion macros shared by the RTL. Define NO_ASSERTIONS to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising clock edge while reset is low.
`define SERL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Checked at every rising clock edge, reset included.
`define SERL_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`else

`define SERL_ASSERT(label, clk, rst, prop)
`define SERL_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

### rtl/serl_pkg.sv
package serl_pkg;

   // Ring depth must be a power of two so that slot arithmetic wraps for free.
   localparam int DEPTH    = 64;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int LIMIT_W  = 6;
   localparam logic [LIMIT_W-1:0] MAX_READ = LIMIT_W'(63);

   // Command queue between the front and back parts.
   localparam int QDEPTH   = 2;
   localparam int QIDX_W   = $clog2(QDEPTH);
   localparam int QCNT_W   = $clog2(QDEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_VALVE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALL_VALVES = 1'b1;
   localparam logic [7:0] NO_VALVE_RESET   = 8'd255;
   localparam logic [7:0] ALL_VALVES_RESET = 8'd254;

   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_READ   = 2'd1,
      OP_GET    = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]         func;
      logic [7:0]         ev_code;
      logic [2:0]         ev_severity;
      logic [7:0]         ev_valve;
      logic signed [31:0] ev_arg_one;
      logic signed [31:0] ev_arg_two;
      logic [31:0]        ev_epoch;
      logic [31:0]        ev_uptime;
      logic [31:0]        since_seq;
      logic [2:0]         min_severity;
      logic [7:0]         filter_valve;
      logic [5:0]         max_out;
   } req_type;

   typedef struct packed {
      logic               has_event;
      logic [31:0]        out_seq;
      logic [7:0]         out_code;
      logic [2:0]         out_severity;
      logic [7:0]         out_valve;
      logic signed [31:0] out_arg_one;
      logic signed [31:0] out_arg_two;
      logic [31:0]        out_epoch;
      logic [31:0]        out_uptime;
      logic [31:0]        next_since;
      logic [5:0]         emitted_count;
      logic               last;
   } rsp_type;

   // Decoded command handed from the front part to the back part.
   typedef struct packed {
      op_type             op;
      logic [7:0]         code;
      logic [2:0]         severity;
      logic [7:0]         valve;
      logic signed [31:0] arg_one;
      logic signed [31:0] arg_two;
      logic [31:0]        epoch;
      logic [31:0]        uptime;
      logic [31:0]        since;
      logic [2:0]         min_severity;
      logic [7:0]         filter_valve;
      logic [LIMIT_W-1:0] limit;
   } cmd_type;

   // One stored ring entry.
   typedef struct packed {
      logic [31:0]        seq;
      logic [7:0]         code;
      logic [2:0]         severity;
      logic [7:0]         valve;
      logic signed [31:0] arg_one;
      logic signed [31:0] arg_two;
      logic [31:0]        epoch;
      logic [31:0]        uptime;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

### rtl/serl_ram.sv
module serl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/serl_front.sv
`include "assert_macros.svh"

module serl_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  serl_pkg::req_type req_word,
   output logic              cmd_valid,
   input  logic              cmd_pop,
   output serl_pkg::cmd_type cmd_word
);

   serl_pkg::cmd_type             q_ff [serl_pkg::QDEPTH];
   logic [serl_pkg::QIDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [serl_pkg::QIDX_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [serl_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   serl_pkg::cmd_type             decoded;
   logic                          push;
   logic                          pop;

   function automatic serl_pkg::cmd_type decode(serl_pkg::req_type r);
      serl_pkg::cmd_type c;
      case (r.func)
         serl_pkg::OP_APPEND: c.op = serl_pkg::OP_APPEND;
         serl_pkg::OP_READ:   c.op = serl_pkg::OP_READ;
         serl_pkg::OP_GET:    c.op = serl_pkg::OP_GET;
         default:             c.op = serl_pkg::OP_CLEAR;
      endcase
      c.code         = r.ev_code;
      c.severity     = r.ev_severity;
      c.valve        = r.ev_valve;
      c.arg_one      = r.ev_arg_one;
      c.arg_two      = r.ev_arg_two;
      c.epoch        = r.ev_epoch;
      c.uptime       = r.ev_uptime;
      c.since        = r.since_seq;
      c.min_severity = r.min_severity;
      c.filter_valve = r.filter_valve;
      c.limit        = (r.max_out > serl_pkg::MAX_READ) ? serl_pkg::MAX_READ : r.max_out;
      return c;
   endfunction

   assign decoded   = decode(req_word);
   assign req_stall = (cnt_ff == serl_pkg::QCNT_W'(serl_pkg::QDEPTH));
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != '0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_word  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= decoded;
      end
   end

   `SERL_ASSERT(a_cnt_bound, clock, reset, cnt_ff <= serl_pkg::QCNT_W'(serl_pkg::QDEPTH))
   `SERL_ASSERT(a_cnt_grows, clock, reset, (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 1'b1))
   `SERL_ASSERT(a_pop_nonempty, clock, reset, pop |-> cnt_ff != '0)

endmodule

### rtl/serl_back.sv
`include "assert_macros.svh"

module serl_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   output logic                              cmd_pop,
   input  serl_pkg::cmd_type                 cmd_word,
   input  logic                              csr_we,
   input  logic [serl_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                        csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output serl_pkg::rsp_type                 rsp_word
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_EVAL   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                     state_ff, state_in;
   serl_pkg::cmd_type             cur_ff, cur_in;
   logic [serl_pkg::IDX_W-1:0]    head_ff, head_in;
   logic [serl_pkg::CNT_W-1:0]    fill_ff, fill_in;
   logic [serl_pkg::CNT_W-1:0]    k_ff, k_in;
   logic [serl_pkg::LIMIT_W-1:0]  n_ff, n_in;
   logic [31:0]                   next_seq_ff, next_seq_in;
   logic [31:0]                   res_seq_ff, res_seq_in;
   logic [31:0]                   resume_ff, resume_in;
   logic [7:0]                    no_valve_ff, all_valves_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   serl_pkg::rsp_type             rsp_word_ff, rsp_word_in;
   logic                          rsp_load;

   logic                          ram_we;
   logic [serl_pkg::IDX_W-1:0]    ram_waddr;
   serl_pkg::entry_type           ram_wentry;
   logic                          ram_re;
   logic [serl_pkg::IDX_W-1:0]    ram_raddr;
   logic [serl_pkg::ENTRY_W-1:0]  ram_rdata;
   serl_pkg::entry_type           entry;

   logic                          out_free;
   logic                          full;
   logic [serl_pkg::CNT_W-1:0]    k_next;
   logic                          scan_end;
   logic                          sev_pass;
   logic                          valve_pass;
   logic                          advance;

   function automatic serl_pkg::rsp_type record_word(serl_pkg::entry_type e, logic is_last);
      serl_pkg::rsp_type r;
      r               = '0;
      r.has_event     = 1'b1;
      r.out_seq       = e.seq;
      r.out_code      = e.code;
      r.out_severity  = e.severity;
      r.out_valve     = e.valve;
      r.out_arg_one   = e.arg_one;
      r.out_arg_two   = e.arg_two;
      r.out_epoch     = e.epoch;
      r.out_uptime    = e.uptime;
      r.last          = is_last;
      return r;
   endfunction

   serl_ram #(
      .WIDTH (serl_pkg::ENTRY_W),
      .DEPTH (serl_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wentry),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign entry    = serl_pkg::entry_type'(ram_rdata);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (fill_ff == serl_pkg::CNT_W'(serl_pkg::DEPTH));
   assign k_next   = k_ff + 1'b1;
   assign scan_end = (k_next == fill_ff);

   assign sev_pass   = (entry.severity >= cur_ff.min_severity);
   assign valve_pass = (cur_ff.filter_valve == no_valve_ff) ||
                       (entry.valve == cur_ff.filter_valve) ||
                       (entry.valve == all_valves_ff);

   // Slot of the appended entry: the oldest one when the ring is full.
   assign ram_waddr = full ? head_ff : head_ff + fill_ff[serl_pkg::IDX_W-1:0];

   always_comb begin
      ram_wentry          = '0;
      ram_wentry.seq      = next_seq_ff;
      ram_wentry.code     = cmd_word.code;
      ram_wentry.severity = cmd_word.severity;
      ram_wentry.valve    = cmd_word.valve;
      ram_wentry.arg_one  = cmd_word.arg_one;
      ram_wentry.arg_two  = cmd_word.arg_two;
      ram_wentry.epoch    = cmd_word.epoch;
      ram_wentry.uptime   = cmd_word.uptime;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      head_in      = head_ff;
      fill_in      = fill_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      next_seq_in  = next_seq_ff;
      res_seq_in   = res_seq_ff;
      resume_in    = resume_ff;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = head_ff + k_next[serl_pkg::IDX_W-1:0];
      rsp_load     = 1'b0;
      rsp_word_in  = '0;
      advance      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop    = 1'b1;
               cur_in     = cmd_word;
               k_in       = '0;
               n_in       = '0;
               resume_in  = cmd_word.since;
               res_seq_in = '0;
               case (cmd_word.op)
                  serl_pkg::OP_APPEND: begin
                     ram_we      = 1'b1;
                     res_seq_in  = next_seq_ff;
                     // Sequence number zero is never handed out.
                     next_seq_in = (next_seq_ff == '1) ? 32'd1 : next_seq_ff + 32'd1;
                     if (full) begin
                        head_in = head_ff + 1'b1;
                     end else begin
                        fill_in = fill_ff + 1'b1;
                     end
                     state_in = ST_FINISH;
                  end
                  serl_pkg::OP_READ, serl_pkg::OP_GET: begin
                     if (fill_ff == '0) begin
                        state_in = ST_FINISH;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = head_ff;
                        state_in  = ST_EVAL;
                     end
                  end
                  default: begin
                     fill_in  = '0;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_EVAL: begin
            // The RAM output holds entry k_ff of the ring, oldest first.
            if (cur_ff.op == serl_pkg::OP_READ) begin
               if (entry.seq <= cur_ff.since) begin
                  advance = 1'b1;
               end else if (n_ff == cur_ff.limit) begin
                  state_in = ST_FINISH;
               end else begin
                  resume_in = entry.seq;
                  if (sev_pass && valve_pass) begin
                     if (out_free) begin
                        rsp_load    = 1'b1;
                        rsp_word_in = record_word(entry, 1'b0);
                        n_in        = n_ff + 1'b1;
                        advance     = 1'b1;
                     end
                  end else begin
                     advance = 1'b1;
                  end
               end
            end else begin
               if (entry.seq == cur_ff.since) begin
                  if (out_free) begin
                     rsp_load    = 1'b1;
                     rsp_word_in = record_word(entry, 1'b1);
                     state_in    = ST_IDLE;
                  end
               end else begin
                  advance = 1'b1;
               end
            end
            if (advance) begin
               if (scan_end) begin
                  state_in = ST_FINISH;
               end else begin
                  ram_re = 1'b1;
                  k_in   = k_next;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               rsp_load  = 1'b1;
               rsp_word_in.last = 1'b1;
               if (cur_ff.op == serl_pkg::OP_APPEND) begin
                  rsp_word_in.out_seq = res_seq_ff;
               end
               if (cur_ff.op == serl_pkg::OP_READ) begin
                  rsp_word_in.next_since    = resume_ff;
                  rsp_word_in.emitted_count = n_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         fill_ff       <= '0;
         next_seq_ff   <= 32'd1;
         rsp_valid_ff  <= 1'b0;
         no_valve_ff   <= serl_pkg::NO_VALVE_RESET;
         all_valves_ff <= serl_pkg::ALL_VALVES_RESET;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         next_seq_ff  <= next_seq_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && csr_index == serl_pkg::CSR_NO_VALVE) begin
            no_valve_ff <= csr_wdata;
         end
         if (csr_we && csr_index == serl_pkg::CSR_ALL_VALVES) begin
            all_valves_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      k_ff       <= k_in;
      n_ff       <= n_in;
      res_seq_ff <= res_seq_in;
      resume_ff  <= resume_in;
      if (rsp_load) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `SERL_ASSERT(a_fill_bound, clock, reset, fill_ff <= serl_pkg::CNT_W'(serl_pkg::DEPTH))
   `SERL_ASSERT(a_scan_in_fill, clock, reset, (state_ff == ST_EVAL) |-> (k_ff < fill_ff))
   `SERL_ASSERT(a_emit_limit, clock, reset, (state_ff == ST_EVAL) |-> (n_ff <= cur_ff.limit))
   `SERL_ASSERT(a_seq_nonzero, clock, reset, next_seq_ff != '0)
   `SERL_ASSERT(a_no_overwrite, clock, reset, (rsp_valid_ff && rsp_stall) |-> !rsp_load)

endmodule

### rtl/sequenced_event_ring_log.sv
// Event log kept in a 64-entry ring. Each request word carries one of four
// operations: append (stores a record, overwriting the oldest when full, and
// returns its sequence number), read (returns the matching records after
// since_seq, oldest first, then a closing word with the resume number and
// count), get (returns the record with the given number, or an empty word)
// and clear. Requests are decoded into a two-entry command queue, so up to
// two words are taken while the store is busy. Read and get scan the ring
// through the single read port of the record RAM, which examines one entry
// per cycle while rsp_stall does not hold a result. The user must write the
// configuration only while idle; the block itself does not enforce it.
module sequenced_event_ring_log (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  serl_pkg::req_type               req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output serl_pkg::rsp_type               rsp_word,
   input  logic                            csr_we,
   input  logic [serl_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [7:0]                      csr_wdata
);

   logic              cmd_valid;
   logic              cmd_pop;
   serl_pkg::cmd_type cmd_word;

   serl_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_word  (cmd_word)
   );

   serl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_word  (cmd_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### tb/sv/sequenced_event_ring_log_test.sv
module sequenced_event_ring_log_test;
   import serl_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RESET_CYCLES  = 5;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;

   // Mirror of the event ring. It turns each accepted request into the
   // response words that the block owes, and checks them as they arrive.
   class ring_log_tracker;
      rsp_type     slots[DEPTH];
      int unsigned oldest;
      int unsigned fill;
      logic [31:0] next_number;
      logic [7:0]  no_valve;
      logic [7:0]  all_valves;
      rsp_type     pending_words[$];
      int unsigned errors;

      function new();
         oldest = 0;
         fill = 0;
         next_number = 1;
         no_valve = NO_VALVE_RESET;
         all_valves = ALL_VALVES_RESET;
         errors = 0;
      endfunction

      function rsp_type plain_word(logic [31:0] seq, logic [31:0] resume, logic [5:0] count);
         rsp_type w;
         w = '0;
         w.out_seq = seq;
         w.next_since = resume;
         w.emitted_count = count;
         w.last = 1'b1;
         return w;
      endfunction

      function void note_request(req_type r);
         rsp_type     rec;
         int unsigned slot;
         int unsigned k;
         int unsigned emitted;
         int unsigned limit;
         logic [31:0] resume;
         bit          found;
         case (r.func)
            OP_APPEND: begin
               // A full ring loses its oldest record to the new one.
               if (fill >= DEPTH) begin
                  slot = oldest;
                  oldest = (oldest + 1) % DEPTH;
               end else begin
                  slot = (oldest + fill) % DEPTH;
                  fill++;
               end
               rec = '0;
               rec.has_event = 1'b1;
               rec.out_seq = next_number;
               rec.out_code = r.ev_code;
               rec.out_severity = r.ev_severity;
               rec.out_valve = r.ev_valve;
               rec.out_arg_one = r.ev_arg_one;
               rec.out_arg_two = r.ev_arg_two;
               rec.out_epoch = r.ev_epoch;
               rec.out_uptime = r.ev_uptime;
               slots[slot] = rec;
               pending_words.push_back(plain_word(next_number, '0, '0));
               next_number++;
               if (next_number == 0) next_number = 1;
            end
            OP_READ: begin
               limit = (r.max_out > MAX_READ) ? MAX_READ : r.max_out;
               resume = r.since_seq;
               emitted = 0;
               for (k = 0; k < fill; k++) begin
                  rec = slots[(oldest + k) % DEPTH];
                  if (rec.out_seq <= r.since_seq) continue;
                  if (emitted == limit) break;
                  // The resume point moves past filtered-out records too.
                  resume = rec.out_seq;
                  if (rec.out_severity < r.min_severity) continue;
                  if (r.filter_valve != no_valve && rec.out_valve != r.filter_valve &&
                      rec.out_valve != all_valves) continue;
                  pending_words.push_back(rec);
                  emitted++;
               end
               pending_words.push_back(plain_word('0, resume, 6'(emitted)));
            end
            OP_GET: begin
               found = 1'b0;
               for (k = 0; k < fill && !found; k++) begin
                  rec = slots[(oldest + k) % DEPTH];
                  if (rec.out_seq == r.since_seq) begin
                     rec.last = 1'b1;
                     pending_words.push_back(rec);
                     found = 1'b1;
                  end
               end
               if (!found) pending_words.push_back(plain_word('0, '0, '0));
            end
            OP_CLEAR: begin
               fill = 0;
               pending_words.push_back(plain_word('0, '0, '0));
            end
         endcase
      endfunction

      function void same(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_word(rsp_type got);
         rsp_type want;
         if (pending_words.size() == 0) begin
            $display("%0t: response word %h with nothing expected", $time, got);
            errors++;
            return;
         end
         want = pending_words.pop_front();
         same("has_event", want.has_event, got.has_event);
         same("out_seq", want.out_seq, got.out_seq);
         same("out_code", want.out_code, got.out_code);
         same("out_severity", want.out_severity, got.out_severity);
         same("out_valve", want.out_valve, got.out_valve);
         same("out_arg_one", want.out_arg_one, got.out_arg_one);
         same("out_arg_two", want.out_arg_two, got.out_arg_two);
         same("out_epoch", want.out_epoch, got.out_epoch);
         same("out_uptime", want.out_uptime, got.out_uptime);
         same("next_since", want.next_since, got.next_since);
         same("emitted_count", want.emitted_count, got.emitted_count);
         same("last", want.last, got.last);
      endfunction
   endclass

   logic                   clock;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_type                req_word = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_type                rsp_word;
   logic                   csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]   csr_index = CSR_NO_VALVE;
   logic [7:0]             csr_wdata = '0;

   ring_log_tracker tracker;
   int unsigned     req_idle_pct = 0;
   int unsigned     rsp_idle_pct = 0;
   bit              hold_request = 1'b0;

   sequenced_event_ring_log DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   // Response side. Inputs change only at rising edges, so the values seen at
   // the falling edge are the ones the next rising edge acts on.
   initial begin : result_side
      int unsigned held;
      held = 0;
      forever begin
         @(posedge clock);
         if (hold_request && held < HOLD_CYCLES) begin
            rsp_stall <= 1'b1;
            held++;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
         end
         @(negedge clock);
         if (!reset && rsp_valid && !rsp_stall) tracker.check_word(rsp_word);
      end
   end

   task automatic send_request(input req_type word);
      bit taken;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= word;
      do begin
         @(negedge clock);
         taken = !reset && !req_stall;
         if (taken) tracker.note_request(word);
         @(posedge clock);
      end while (!taken);
   endtask

   task automatic write_filter_codes(input logic [7:0] no_valve, input logic [7:0] all_valves);
      csr_we <= 1'b1;
      csr_index <= CSR_NO_VALVE;
      csr_wdata <= no_valve;
      @(posedge clock);
      csr_index <= CSR_ALL_VALVES;
      csr_wdata <= all_valves;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.no_valve = no_valve;
      tracker.all_valves = all_valves;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (tracker.pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic req_type record_request(logic [7:0] code, logic [2:0] sev,
                                              logic [7:0] valve, logic signed [31:0] arg_one,
                                              logic signed [31:0] arg_two, logic [31:0] epoch,
                                              logic [31:0] uptime);
      req_type w;
      w = '0;
      w.func = OP_APPEND;
      w.ev_code = code;
      w.ev_severity = sev;
      w.ev_valve = valve;
      w.ev_arg_one = arg_one;
      w.ev_arg_two = arg_two;
      w.ev_epoch = epoch;
      w.ev_uptime = uptime;
      return w;
   endfunction

   function automatic req_type scan_request(op_type op, logic [31:0] since, logic [2:0] min_sev,
                                            logic [7:0] valve, logic [5:0] max_out);
      req_type w;
      w = '0;
      w.func = op;
      w.since_seq = since;
      w.min_severity = min_sev;
      w.filter_valve = valve;
      w.max_out = max_out;
      return w;
   endfunction

   // Every field is randomized whatever the operation, so unused fields toggle
   // as well. Valves cluster on a few values so that filters find matches.
   function automatic req_type random_request(op_type op);
      req_type     w;
      int unsigned pick;
      w.func = op;
      w.ev_code = 8'($urandom);
      w.ev_severity = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 4))
                                                   : 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 99);
      if (pick < 40)      w.ev_valve = 8'($urandom_range(0, 3));
      else if (pick < 55) w.ev_valve = tracker.all_valves;
      else if (pick < 65) w.ev_valve = tracker.no_valve;
      else                w.ev_valve = 8'($urandom);
      w.ev_arg_one = $urandom;
      w.ev_arg_two = $urandom;
      w.ev_epoch = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom);
      w.ev_uptime = $urandom;
      pick = $urandom_range(0, 99);
      if (op == OP_GET) begin
         if (pick < 60 && tracker.fill > 0)
            w.since_seq = tracker.slots[(tracker.oldest + $urandom_range(0, tracker.fill - 1))
                                       % DEPTH].out_seq;
         else if (pick < 70) w.since_seq = '0;
         else if (pick < 85) w.since_seq = $urandom_range(0, tracker.next_number);
         else                w.since_seq = $urandom;
      end else begin
         if (pick < 25)      w.since_seq = '0;
         else if (pick < 75) w.since_seq = $urandom_range(0, tracker.next_number);
         else if (pick < 85) w.since_seq = tracker.next_number - 1;
         else                w.since_seq = $urandom;
      end
      w.min_severity = ($urandom_range(0, 99) < 80) ? 3'($urandom_range(0, 4))
                                                    : 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 99);
      if (pick < 30)      w.filter_valve = tracker.no_valve;
      else if (pick < 70) w.filter_valve = 8'($urandom_range(0, 3));
      else if (pick < 80) w.filter_valve = tracker.all_valves;
      else                w.filter_valve = 8'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 10)      w.max_out = '0;
      else if (pick < 20) w.max_out = 6'd63;
      else if (pick < 60) w.max_out = 6'($urandom_range(1, 8));
      else                w.max_out = 6'($urandom);
      return w;
   endfunction

   // Appends often come in bursts so that the ring fills and wraps between
   // the occasional clears.
   task automatic run_random(input int unsigned count);
      int unsigned sent;
      int unsigned pick;
      int unsigned burst;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 70) : 1;
            if (burst > count - sent) burst = count - sent;
            repeat (burst) send_request(random_request(OP_APPEND));
            sent += burst;
         end else begin
            if (pick < 80)      send_request(random_request(OP_READ));
            else if (pick < 97) send_request(random_request(OP_GET));
            else                send_request(random_request(OP_CLEAR));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      req_type opening[$];
      tracker = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      opening.push_back(scan_request(OP_READ, 0, 0, NO_VALVE_RESET, 5));
      opening.push_back(scan_request(OP_GET, 0, 0, 0, 0));
      opening.push_back(record_request(8'd0, 3'd0, 8'd0, 32'sh80000000, 32'sh80000000, 0, 0));
      opening.push_back(record_request(8'd255, 3'd7, 8'd255, 32'sh7fffffff, 32'sh7fffffff,
                                       32'hffffffff, 32'hffffffff));
      opening.push_back(record_request(8'h5a, 3'd4, ALL_VALVES_RESET, -1, 0, 1000, 17));
      opening.push_back(record_request(8'h11, 3'd5, 8'd3, 1, -1, 0, 99));
      opening.push_back(record_request(8'h22, 3'd2, 8'd3, 12, -12, 5, 6));
      opening.push_back(scan_request(OP_READ, 0, 0, NO_VALVE_RESET, 63));
      opening.push_back(scan_request(OP_READ, 2, 0, NO_VALVE_RESET, 0));
      opening.push_back(scan_request(OP_READ, 0, 4, 8'd3, 63));
      opening.push_back(scan_request(OP_READ, 0, 0, 8'd0, 2));
      opening.push_back(scan_request(OP_READ, 5, 0, NO_VALVE_RESET, 63));
      opening.push_back(scan_request(OP_READ, 32'hffffffff, 0, NO_VALVE_RESET, 63));
      opening.push_back(scan_request(OP_READ, 0, 7, NO_VALVE_RESET, 63));
      opening.push_back(scan_request(OP_GET, 3, 0, 0, 0));
      opening.push_back(scan_request(OP_GET, 0, 0, 0, 0));
      opening.push_back(scan_request(OP_GET, 99, 0, 0, 0));
      opening.push_back(scan_request(OP_CLEAR, 0, 0, 0, 0));
      opening.push_back(scan_request(OP_READ, 0, 0, NO_VALVE_RESET, 63));
      opening.push_back(scan_request(OP_GET, 2, 0, 0, 0));
      opening.push_back(record_request(8'h33, 3'd1, 8'd1, 7, 8, 9, 10));
      opening.push_back(scan_request(OP_GET, 6, 0, 0, 0));
      opening.push_back(scan_request(OP_READ, 0, 0, NO_VALVE_RESET, 63));
      foreach (opening[i]) send_request(opening[i]);
      drain_responses();

      write_filter_codes(8'd0, 8'd255);
      req_idle_pct = 35;
      rsp_idle_pct = 68;
      run_random(135);
      drain_responses();

      write_filter_codes(8'd255, 8'd0);
      req_idle_pct = 68;
      rsp_idle_pct = 35;
      run_random(135);
      drain_responses();

      // Codes among the common valves make the two special codes collide
      // with ordinary records. The long response hold fills the block.
      write_filter_codes(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 1'b1;
      run_random(130);
      drain_responses();

      repeat (DEPTH) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_words.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/serl_pkg.sv
rtl/serl_ram.sv
rtl/serl_front.sv
rtl/serl_back.sv
rtl/sequenced_event_ring_log.sv
tb/sv/sequenced_event_ring_log_test.sv
